// ----- sv/speaker_activity_segmenter_defines.svh -----
// Assertion macros used by the checker of the segmenter.
// Each macro expects signals named clk and rst_n in scope.
`ifndef SPEAKER_ACTIVITY_SEGMENTER_DEFINES_SVH
`define SPEAKER_ACTIVITY_SEGMENTER_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define SAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define SAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sas_pkg.sv -----
// ----------------------------------------------------------------------------
// sas_pkg
// Shared constants and types of the speaker activity segmenter.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int PROB_FIELDS  = 4;
  localparam int PROB_W       = 16;
  localparam int FRAME_W      = 32;
  localparam int MS_W         = 10;
  localparam int TIME_W       = 42;
  localparam int SPK_NUM_W    = 3;
  localparam int SPEAKERS_DEF = 4;
  localparam int QDEPTH_DEF   = 2;

  localparam logic [PROB_W-1:0]  HALF_SCALED    = 16'd32768;
  localparam logic [MS_W-1:0]    FRAME_MS_RESET = 10'd80;
  localparam logic [FRAME_W-1:0] FRAME_MAX      = '1;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- sv/sas_queue.sv -----
// ----------------------------------------------------------------------------
// sas_queue
// Small register FIFO carrying close jobs from the front to the back end.
// ----------------------------------------------------------------------------
module sas_queue
  import sas_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output qstat_t       stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/sas_front.sv -----
// ----------------------------------------------------------------------------
// sas_front
// Takes requests, tracks open runs and the frame counter, and queues one
// close job (closing mask, start frames, end frame) per request that ends runs.
// ----------------------------------------------------------------------------
module sas_front
  import sas_pkg::*;
#(
  parameter int SPEAKERS = SPEAKERS_DEF,
  parameter int JW       = SPEAKERS * (FRAME_W + 1) + FRAME_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [PROB_FIELDS-1:0][PROB_W-1:0] in_prob,
  input  qstat_t                            qstat,
  output logic                              push,
  output logic [JW-1:0]                     push_data
);

  localparam int SPK_USED = (SPEAKERS < PROB_FIELDS) ? SPEAKERS : PROB_FIELDS;

  logic [SPEAKERS-1:0]              open_r, open_nxt;
  logic [SPEAKERS-1:0][FRAME_W-1:0] start_r, start_nxt;
  logic [FRAME_W-1:0]               fc_r, fc_nxt;
  logic [SPEAKERS-1:0]              close_mask;
  logic                             accept;

  assign in_ready  = !qstat.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (close_mask != '0);
  assign push_data = {fc_r, start_r, close_mask};

  for (genvar gs = 0; gs < SPEAKERS; gs++) begin : g_spk
    if (gs < SPK_USED) begin : g_used
      logic active;
      logic is_frame;
      assign active          = in_prob[gs] > HALF_SCALED;
      assign is_frame        = (in_op == OP_FRAME);
      assign close_mask[gs]  = open_r[gs] && (!is_frame || !active);
      // a frame leaves exactly the active speakers open; close-all clears all
      assign open_nxt[gs]    = is_frame && active;
      assign start_nxt[gs]   = (is_frame && active && !open_r[gs]) ? fc_r : start_r[gs];
    end else begin : g_unused
      // no probability field: never active
      assign close_mask[gs]  = 1'b0;
      assign open_nxt[gs]    = 1'b0;
      assign start_nxt[gs]   = start_r[gs];
    end
  end

  assign fc_nxt = ((in_op == OP_FRAME) && (fc_r != FRAME_MAX)) ? fc_r + FRAME_W'(1) : fc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      fc_r   <= '0;
    end else if (accept) begin
      open_r <= open_nxt;
      fc_r   <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= start_nxt;
    end
  end

endmodule

// ----- sv/sas_back.sv -----
// ----------------------------------------------------------------------------
// sas_back
// Walks the head close job in ascending speaker order, one segment a cycle if
// not stalled, scales frames to ms, holds the result in the output register.
// ----------------------------------------------------------------------------
module sas_back
  import sas_pkg::*;
#(
  parameter int SPEAKERS = SPEAKERS_DEF,
  parameter int JW       = SPEAKERS * (FRAME_W + 1) + FRAME_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [MS_W-1:0]      frame_ms,
  input  qstat_t               qstat,
  input  logic [JW-1:0]        head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SPK_NUM_W-1:0] out_spk,
  output logic [TIME_W-1:0]    out_start,
  output logic [TIME_W-1:0]    out_end,
  output logic                 out_last
);

  localparam int SPK_W = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;

  logic [SPEAKERS-1:0]              mask;
  logic [SPEAKERS-1:0][FRAME_W-1:0] starts;
  logic [FRAME_W-1:0]               end_frame;
  logic [SPEAKERS-1:0]              done_r, done_nxt;
  logic [SPEAKERS-1:0]              rem, sel_oh;
  logic [SPK_W-1:0]                 sel_idx;
  logic                             issue, last;
  logic [TIME_W-1:0]                start_prod, end_prod;

  logic                 out_valid_r;
  logic [SPK_NUM_W-1:0] out_spk_r;
  logic [TIME_W-1:0]    out_start_r, out_end_r;
  logic                 out_last_r;

  assign mask      = head_data[SPEAKERS-1:0];
  assign starts    = head_data[SPEAKERS*(FRAME_W+1)-1:SPEAKERS];
  assign end_frame = head_data[JW-1 -: FRAME_W];

  assign rem = mask & ~done_r;

  // lowest pending speaker first
  always_comb begin
    sel_idx = '0;
    sel_oh  = '0;
    for (int s = SPEAKERS - 1; s >= 0; s--) begin
      if (rem[s]) begin
        sel_idx = SPK_W'(s);
        sel_oh  = '0;
        sel_oh[s] = 1'b1;
      end
    end
  end

  assign last  = (rem & ~sel_oh) == '0;
  assign issue = !qstat.empty && (!out_valid_r || out_ready);
  assign pop   = issue && last;

  always_comb begin
    done_nxt = done_r;
    if (issue) begin
      done_nxt = last ? '0 : (done_r | sel_oh);
    end
  end

  assign start_prod = TIME_W'(starts[sel_idx]) * TIME_W'(frame_ms);
  assign end_prod   = TIME_W'(end_frame) * TIME_W'(frame_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_spk_r   <= SPK_NUM_W'(sel_idx) + SPK_NUM_W'(1);
      out_start_r <= start_prod;
      out_end_r   <= end_prod;
      out_last_r  <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_spk   = out_spk_r;
  assign out_start = out_start_r;
  assign out_end   = out_end_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/speaker_activity_segmenter.sv -----
// ----------------------------------------------------------------------------
// speaker_activity_segmenter
// Turns per-frame speaker activity into closed segments with ms timestamps.
// ----------------------------------------------------------------------------
// A request is taken whenever the job queue (two entries) has room;
// requests that close no run never occupy the queue and flow at one per
// cycle while it is not full. A request that closes k runs (k at most four)
// yields k segments, one per cycle from the back end's frame-to-ms multiplier
// while the output is not stalled. The first segment passes through the queue
// entry and the back end's output register. frame_ms is read when a segment
// is formed and must only change while the block is idle.
module speaker_activity_segmenter
  import sas_pkg::*;
#(
  parameter int SPEAKERS = SPEAKERS_DEF,
  parameter int QDEPTH   = QDEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // prob_spk0[15:0], prob_spk1[31:16], prob_spk2[47:32], prob_spk3[63:48]
  input  logic [63:0]     in_tdata,
  // operation[0]
  input  logic            in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  // speaker_number[2:0], start_ms[44:3], end_ms[86:45], zero pad[87]
  output logic [87:0]     out_tdata,
  output logic            out_tlast,
  input  logic            cfg_we,
  input  logic [MS_W-1:0] cfg_wdata
);

  localparam int JW = SPEAKERS * (FRAME_W + 1) + FRAME_W;

  logic [MS_W-1:0]                   frame_ms_r;
  logic [PROB_FIELDS-1:0][PROB_W-1:0] probs;
  qstat_t                            qstat;
  logic                              push, pop;
  logic [JW-1:0]                     push_data, head_data;
  logic [SPK_NUM_W-1:0]              seg_spk;
  logic [TIME_W-1:0]                 seg_start, seg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ms_r <= FRAME_MS_RESET;
    end else if (cfg_we) begin
      frame_ms_r <= cfg_wdata;
    end
  end

  for (genvar gf = 0; gf < PROB_FIELDS; gf++) begin : g_prob
    assign probs[gf] = in_tdata[gf*PROB_W +: PROB_W];
  end

  sas_front #(
    .SPEAKERS (SPEAKERS),
    .JW       (JW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_prob   (probs),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  sas_queue #(
    .W     (JW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (qstat)
  );

  sas_back #(
    .SPEAKERS (SPEAKERS),
    .JW       (JW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_ms  (frame_ms_r),
    .qstat     (qstat),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_spk   (seg_spk),
    .out_start (seg_start),
    .out_end   (seg_end),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, seg_end, seg_start, seg_spk};

endmodule

// ----- sv/sas_checker.sv -----
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`include "speaker_activity_segmenter_defines.svh"

module sas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tlast
);

  logic out_take;
  assign out_take = out_tvalid && out_tready;

  // stalled segment must hold
  `SAS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "segment changed under stall")

  // segments of one request come out back to back
  `SAS_ASSERT_NXT(a_burst_gapless, out_take && !out_tlast,
    out_tvalid, "gap inside a segment burst")

  // ascending speaker order within a request
  `SAS_ASSERT_NXT(a_spk_ascending, out_take && !out_tlast,
    out_tdata[2:0] > $past(out_tdata[2:0]), "speaker order not ascending")

  // a run never ends before it starts
  `SAS_ASSERT_IMP(a_end_after_start, out_tvalid,
    out_tdata[86:45] >= out_tdata[44:3], "segment ends before it starts")

endmodule

bind speaker_activity_segmenter sas_checker u_sas_checker (.*);
